>>> design/v3a_pkg.sv
package v3a_pkg;

    localparam int IN_W          = 32;
    localparam int CMD_W         = 4;
    localparam int FLOOR_W       = 31;
    localparam int PROD_W        = 66;
    localparam int SUM_W         = 68;
    localparam int VAL_W         = 68;
    localparam int RAD_W         = 66;
    localparam int ROOT_W        = 33;
    localparam int DEN_W         = 33;
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_SCALE = 4'd2,
        CMD_DIV   = 4'd3,
        CMD_DOT   = 4'd4,
        CMD_CROSS = 4'd5,
        CMD_LENSQ = 4'd6,
        CMD_LEN   = 4'd7,
        CMD_NORM  = 4'd8,
        CMD_DIST  = 4'd9,
        CMD_LERP  = 4'd10
    } t_cmd;

    // Transaction state while the square root is being worked out.
    typedef struct packed {
        t_cmd                   cmd;
        logic [2:0][IN_W-1:0]   a;
        logic [IN_W-1:0]        s;
        logic [2:0][VAL_W-1:0]  vv;
        logic [VAL_W-1:0]       rs;
    } t_mid;

    // Transaction state while the lane dividers are working.
    typedef struct packed {
        t_cmd                   cmd;
        logic [2:0][VAL_W-1:0]  vv;
        logic [VAL_W-1:0]       rs;
        logic [ROOT_W-1:0]      root;
        logic                   dz;
    } t_tail;

endpackage

>>> design/v3a_if.sv
interface v3a_in_if;
    logic                                valid;
    logic                                ready;
    logic [v3a_pkg::CMD_W-1:0]           cmd;
    logic signed [v3a_pkg::IN_W-1:0]     a_x;
    logic signed [v3a_pkg::IN_W-1:0]     a_y;
    logic signed [v3a_pkg::IN_W-1:0]     a_z;
    logic signed [v3a_pkg::IN_W-1:0]     b_x;
    logic signed [v3a_pkg::IN_W-1:0]     b_y;
    logic signed [v3a_pkg::IN_W-1:0]     b_z;
    logic signed [v3a_pkg::IN_W-1:0]     s_in;

    modport source (output valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, s_in, input ready);
    modport sink   (input valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, s_in, output ready);
endinterface

interface v3a_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [v3a_pkg::IN_W-1:0]     r_x;
    logic signed [v3a_pkg::IN_W-1:0]     r_y;
    logic signed [v3a_pkg::IN_W-1:0]     r_z;
    logic signed [v3a_pkg::IN_W-1:0]     r_s;
    logic                                saturated;

    modport source (output valid, r_x, r_y, r_z, r_s, saturated, input ready);
    modport sink   (input valid, r_x, r_y, r_z, r_s, saturated, output ready);
endinterface

>>> design/v3a_lane.sv
module v3a_lane (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  v3a_pkg::t_cmd                      i_cmd,
    input  logic signed [v3a_pkg::IN_W-1:0]    i_a_i,
    input  logic signed [v3a_pkg::IN_W-1:0]    i_a_j,
    input  logic signed [v3a_pkg::IN_W-1:0]    i_a_k,
    input  logic signed [v3a_pkg::IN_W-1:0]    i_b_i,
    input  logic signed [v3a_pkg::IN_W-1:0]    i_b_j,
    input  logic signed [v3a_pkg::IN_W-1:0]    i_b_k,
    input  logic signed [v3a_pkg::IN_W-1:0]    i_s,
    output logic signed [v3a_pkg::PROD_W-1:0]  o_p0,
    output logic signed [v3a_pkg::PROD_W-1:0]  o_p1
);
    import v3a_pkg::*;

    logic signed [IN_W:0]     x0, y0, x1, y1;
    logic signed [IN_W:0]     ea, eb, es;
    logic signed [PROD_W-1:0] n_p0, n_p1;
    logic signed [PROD_W-1:0] r_p0, r_p1;

    always_comb begin
        ea = $signed({i_a_i[IN_W-1], i_a_i});
        eb = $signed({i_b_i[IN_W-1], i_b_i});
        es = $signed({i_s[IN_W-1], i_s});
        x0 = '0;
        y0 = '0;
        x1 = '0;
        y1 = '0;
        case (i_cmd)
            CMD_SCALE: begin
                x0 = ea;
                y0 = es;
            end
            CMD_DOT: begin
                x0 = ea;
                y0 = eb;
            end
            CMD_LENSQ, CMD_LEN, CMD_NORM: begin
                x0 = ea;
                y0 = ea;
            end
            CMD_DIST: begin
                x0 = ea - eb;
                y0 = ea - eb;
            end
            CMD_CROSS: begin
                x0 = $signed({i_a_j[IN_W-1], i_a_j});
                y0 = $signed({i_b_k[IN_W-1], i_b_k});
                x1 = $signed({i_a_k[IN_W-1], i_a_k});
                y1 = $signed({i_b_j[IN_W-1], i_b_j});
            end
            CMD_LERP: begin
                x0 = es;
                y0 = eb - ea;
            end
            default: begin
                x0 = '0;
            end
        endcase
        n_p0 = PROD_W'(x0) * PROD_W'(y0);
        n_p1 = PROD_W'(x1) * PROD_W'(y1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
        end
    end

    assign o_p0 = r_p0;
    assign o_p1 = r_p1;

endmodule

>>> design/v3a_sqrt.sv
module v3a_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [v3a_pkg::RAD_W-1:0]     i_rad,
    output logic [v3a_pkg::ROOT_W-1:0]    o_root
);
    import v3a_pkg::*;

    logic [RAD_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];

    // One result bit per stage, most significant first; the remainder holds N - root^2.
    always_comb begin
        logic [RAD_W:0]    rp;
        logic [RAD_W:0]    t;
        logic [ROOT_W-1:0] op;
        int                b;
        for (int k = 0; k < ROOT_W; k++) begin
            b  = ROOT_W - 1 - k;
            rp = (k == 0) ? {1'b0, i_rad} : {1'b0, r_rem[(k == 0) ? 0 : k - 1]};
            op = (k == 0) ? '0 : r_root[(k == 0) ? 0 : k - 1];
            t  = ((RAD_W + 1)'(op) << (b + 1)) | ((RAD_W + 1)'(1) << (2 * b));
            if (rp >= t) begin
                n_rem[k]  = RAD_W'(rp - t);
                n_root[k] = op | (ROOT_W'(1) << b);
            end else begin
                n_rem[k]  = rp[RAD_W-1:0];
                n_root[k] = op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

>>> design/v3a_div.sv
module v3a_div #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [v3a_pkg::IN_W+FRAC_BITS-1:0]     i_num,
    input  logic [v3a_pkg::DEN_W-1:0]              i_den,
    input  logic                                   i_neg,
    output logic [v3a_pkg::IN_W+FRAC_BITS-1:0]     o_q,
    output logic                                   o_rem_nz,
    output logic                                   o_neg
);
    import v3a_pkg::*;

    localparam int NUM_W = IN_W + FRAC_BITS;

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic             r_neg [NUM_W];
    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [NUM_W-1:0] n_nq  [NUM_W];
    logic [DEN_W-1:0] den_p [NUM_W];
    logic             neg_p [NUM_W];

    // Restoring division of magnitudes; numerator bits shift out as quotient bits shift in.
    always_comb begin
        logic [DEN_W-1:0] rp;
        logic [NUM_W-1:0] qp;
        logic [DEN_W:0]   t;
        for (int k = 0; k < NUM_W; k++) begin
            rp       = (k == 0) ? '0    : r_rem[(k == 0) ? 0 : k - 1];
            qp       = (k == 0) ? i_num : r_nq[(k == 0) ? 0 : k - 1];
            den_p[k] = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            neg_p[k] = (k == 0) ? i_neg : r_neg[(k == 0) ? 0 : k - 1];
            t        = {rp, qp[NUM_W-1]};
            if (t >= {1'b0, den_p[k]}) begin
                n_rem[k] = DEN_W'(t - {1'b0, den_p[k]});
                n_nq[k]  = {qp[NUM_W-2:0], 1'b1};
            end else begin
                n_rem[k] = t[DEN_W-1:0];
                n_nq[k]  = {qp[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_den[k] <= den_p[k];
                r_neg[k] <= neg_p[k];
            end
        end
    end

    assign o_q      = r_nq[NUM_W-1];
    assign o_rem_nz = |r_rem[NUM_W-1];
    assign o_neg    = r_neg[NUM_W-1];

endmodule

>>> design/vector3_alu.sv
// Three-component vector unit in signed fixed point, Q16.16 by default. It accepts one
// transaction per cycle while the output is not held, and returns results in order. Every
// operation runs through the same pipeline: a multiplier lane per component, a merging stage,
// a 33-stage square root and a divider lane per component with one stage per quotient bit;
// that depth sets the latency. While a result waits at the output the whole pipeline holds
// and no new transaction is taken.
module vector3_alu #(
    parameter int WORD_BITS = v3a_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    v3a_in_if.sink                          i_in,
    v3a_out_if.source                       o_out,
    input  logic                            i_cfg_wr_en,
    input  logic [v3a_pkg::FLOOR_W-1:0]     i_cfg_wr_data
);
    import v3a_pkg::*;

    localparam int RES_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int NUM_W    = IN_W + FRAC_BITS;
    localparam int N_ST     = ROOT_W + NUM_W + 3;
    localparam logic signed [VAL_W-1:0] SAT_HI = (VAL_W'(1) << (RES_BITS - 1)) - VAL_W'(1);
    localparam logic signed [VAL_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [IN_W-1:0] OUT_HI = SAT_HI[IN_W-1:0];
    localparam logic [IN_W-1:0] OUT_LO = SAT_LO[IN_W-1:0];

    logic                     en, acc;
    logic [N_ST-1:0]          r_vld;
    logic [FLOOR_W-1:0]       r_floor;
    t_cmd                     in_cmd;
    logic signed [IN_W-1:0]   in_a [3];
    logic signed [IN_W-1:0]   in_b [3];
    logic signed [PROD_W-1:0] p0 [3];
    logic signed [PROD_W-1:0] p1 [3];
    logic signed [IN_W:0]     n_as [3];

    t_cmd                     r1_cmd;
    logic signed [IN_W-1:0]   r1_a [3];
    logic signed [IN_W-1:0]   r1_s;
    logic signed [IN_W:0]     r1_as [3];

    logic signed [SUM_W-1:0]  sum;
    logic signed [PROD_W:0]   cdiff [3];
    t_mid                     n_mid, r_mid;
    logic [RAD_W-1:0]         r_rad;
    t_mid                     r_mdl [ROOT_W];
    logic [ROOT_W-1:0]        root;

    t_mid                     mid_o;
    logic                     is_div, is_norm;
    logic [IN_W-1:0]          s_mag;
    logic [NUM_W-1:0]         d_num [3];
    logic [DEN_W-1:0]         d_den;
    logic                     d_neg [3];
    t_tail                    n_tail;
    t_tail                    r_tdl [NUM_W];
    t_tail                    tail;
    logic [NUM_W-1:0]         q [3];
    logic                     rnz [3];
    logic                     qneg [3];

    logic signed [VAL_W-1:0]  fv [4];
    logic [IN_W-1:0]          ov [4];
    logic                     n_sat;
    logic [IN_W-1:0]          r_ox, r_oy, r_oz, r_os;
    logic                     r_osat;

    assign en         = !r_vld[N_ST-1] || o_out.ready;
    assign acc        = i_in.valid && en;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_floor <= FLOOR_W'(1);
        end else begin
            if (en) begin
                r_vld <= {r_vld[N_ST-2:0], acc};
            end
            if (i_cfg_wr_en) begin
                r_floor <= i_cfg_wr_data;
            end
        end
    end

    assign in_cmd  = t_cmd'(i_in.cmd);
    assign in_a[0] = i_in.a_x;
    assign in_a[1] = i_in.a_y;
    assign in_a[2] = i_in.a_z;
    assign in_b[0] = i_in.b_x;
    assign in_b[1] = i_in.b_y;
    assign in_b[2] = i_in.b_z;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        v3a_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_cmd (in_cmd),
            .i_a_i (in_a[i]),
            .i_a_j (in_a[(i + 1) % 3]),
            .i_a_k (in_a[(i + 2) % 3]),
            .i_b_i (in_b[i]),
            .i_b_j (in_b[(i + 1) % 3]),
            .i_b_k (in_b[(i + 2) % 3]),
            .i_s   (i_in.s_in),
            .o_p0  (p0[i]),
            .o_p1  (p1[i])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (in_cmd == CMD_SUB) begin
                n_as[i] = (IN_W + 1)'(in_a[i]) - (IN_W + 1)'(in_b[i]);
            end else begin
                n_as[i] = (IN_W + 1)'(in_a[i]) + (IN_W + 1)'(in_b[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd <= in_cmd;
            r1_s   <= i_in.s_in;
            for (int i = 0; i < 3; i++) begin
                r1_a[i]  <= in_a[i];
                r1_as[i] <= n_as[i];
            end
        end
    end

    // Merging stage: per-lane results and the sum of the three lane products.
    always_comb begin
        sum = SUM_W'(p0[0]) + SUM_W'(p0[1]) + SUM_W'(p0[2]);
        n_mid.cmd = r1_cmd;
        n_mid.s   = r1_s;
        n_mid.rs  = '0;
        if (r1_cmd == CMD_DOT || r1_cmd == CMD_LENSQ) begin
            n_mid.rs = VAL_W'(sum >>> FRAC_BITS);
        end
        for (int i = 0; i < 3; i++) begin
            cdiff[i]   = (PROD_W + 1)'(p0[i]) - (PROD_W + 1)'(p1[i]);
            n_mid.a[i] = r1_a[i];
            case (r1_cmd)
                CMD_ADD, CMD_SUB: n_mid.vv[i] = VAL_W'(r1_as[i]);
                CMD_SCALE:        n_mid.vv[i] = VAL_W'(p0[i] >>> FRAC_BITS);
                CMD_CROSS:        n_mid.vv[i] = VAL_W'(cdiff[i] >>> FRAC_BITS);
                CMD_LERP:         n_mid.vv[i] = VAL_W'(r1_a[i]) + VAL_W'(p0[i] >>> FRAC_BITS);
                default:          n_mid.vv[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mid <= n_mid;
            r_rad <= sum[RAD_W-1:0];
        end
    end

    v3a_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_rad),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mdl[0] <= r_mid;
            for (int k = 1; k < ROOT_W; k++) begin
                r_mdl[k] <= r_mdl[k-1];
            end
        end
    end

    assign mid_o = r_mdl[ROOT_W-1];

    always_comb begin
        logic [IN_W-1:0] a_mag;
        is_div  = (mid_o.cmd == CMD_DIV);
        is_norm = (mid_o.cmd == CMD_NORM);
        s_mag   = mid_o.s[IN_W-1] ? -mid_o.s : mid_o.s;
        d_den   = is_div ? DEN_W'(s_mag) : root;
        for (int i = 0; i < 3; i++) begin
            a_mag    = mid_o.a[i][IN_W-1] ? -mid_o.a[i] : mid_o.a[i];
            d_num[i] = {a_mag, FRAC_BITS'(0)};
            d_neg[i] = mid_o.a[i][IN_W-1] ^ (is_div & mid_o.s[IN_W-1]);
        end
        n_tail.cmd  = mid_o.cmd;
        n_tail.vv   = mid_o.vv;
        n_tail.rs   = mid_o.rs;
        n_tail.root = root;
        n_tail.dz   = is_div ? (mid_o.s == '0) : (root <= ROOT_W'(r_floor));
        if (!is_div && !is_norm) begin
            n_tail.dz = 1'b0;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        v3a_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_num    (d_num[i]),
            .i_den    (d_den),
            .i_neg    (d_neg[i]),
            .o_q      (q[i]),
            .o_rem_nz (rnz[i]),
            .o_neg    (qneg[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tdl[0] <= n_tail;
            for (int k = 1; k < NUM_W; k++) begin
                r_tdl[k] <= r_tdl[k-1];
            end
        end
    end

    assign tail = r_tdl[NUM_W-1];

    // Quotients are floored, then every result is clamped to the output range.
    always_comb begin
        logic signed [VAL_W-1:0] qv;
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            qv = qneg[i] ? -(VAL_W'(q[i]) + VAL_W'(rnz[i])) : VAL_W'(q[i]);
            if (tail.cmd == CMD_DIV || tail.cmd == CMD_NORM) begin
                fv[i] = tail.dz ? '0 : qv;
            end else begin
                fv[i] = tail.vv[i];
            end
        end
        if (tail.cmd == CMD_LEN || tail.cmd == CMD_DIST) begin
            fv[3] = VAL_W'(tail.root);
        end else begin
            fv[3] = tail.rs;
        end
        for (int j = 0; j < 4; j++) begin
            if (fv[j] > SAT_HI) begin
                ov[j] = OUT_HI;
                n_sat = 1'b1;
            end else if (fv[j] < SAT_LO) begin
                ov[j] = OUT_LO;
                n_sat = 1'b1;
            end else begin
                ov[j] = fv[j][IN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox   <= ov[0];
            r_oy   <= ov[1];
            r_oz   <= ov[2];
            r_os   <= ov[3];
            r_osat <= n_sat;
        end
    end

    assign o_out.valid     = r_vld[N_ST-1];
    assign o_out.r_x       = r_ox;
    assign o_out.r_y       = r_oy;
    assign o_out.r_z       = r_oz;
    assign o_out.r_s       = r_os;
    assign o_out.saturated = r_osat;

    a_reset_empty : assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("Result presented straight after reset.");

    a_sat_at_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |->
            (o_out.r_x == OUT_HI || o_out.r_x == OUT_LO || o_out.r_y == OUT_HI ||
             o_out.r_y == OUT_LO || o_out.r_z == OUT_HI || o_out.r_z == OUT_LO ||
             o_out.r_s == OUT_HI || o_out.r_s == OUT_LO))
        else $error("Saturation flagged but no field sits at a limit.");

    a_scalar_or_vector : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.r_s != '0) |->
            (o_out.r_x == '0 && o_out.r_y == '0 && o_out.r_z == '0))
        else $error("Scalar and vector result both non-zero.");

endmodule
